[design/kclc_pkg.sv]
// Shared types and constants of the keypad code lock controller.
package kclc_pkg;

  // Key event codes carried in the action field.
  localparam logic [1:0] ACT_DIGIT = 2'd0;
  localparam logic [1:0] ACT_DOWN  = 2'd1;
  localparam logic [1:0] ACT_ENTER = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  // Menu options.
  localparam logic [1:0] MENU_ENTER  = 2'd0;
  localparam logic [1:0] MENU_SET    = 2'd1;
  localparam logic [1:0] MENU_CHANGE = 2'd2;
  localparam logic [1:0] MENU_SOUND  = 2'd3;

  // Result status codes.
  localparam logic [3:0] ST_NONE        = 4'd0;
  localparam logic [3:0] ST_MENU_MOVED  = 4'd1;
  localparam logic [3:0] ST_ENTRY_START = 4'd2;
  localparam logic [3:0] ST_DIGIT_TAKEN = 4'd3;
  localparam logic [3:0] ST_STORED      = 4'd4;
  localparam logic [3:0] ST_ALREADY_SET = 4'd5;
  localparam logic [3:0] ST_SET_FIRST   = 4'd6;
  localparam logic [3:0] ST_OPENED      = 4'd7;
  localparam logic [3:0] ST_WRONG       = 4'd8;
  localparam logic [3:0] ST_WRONG_LOCK  = 4'd9;
  localparam logic [3:0] ST_LOCK_IGNORE = 4'd10;
  localparam logic [3:0] ST_RELEASED    = 4'd11;
  localparam logic [3:0] ST_OLD_OK      = 4'd12;
  localparam logic [3:0] ST_SOUND_TOGG  = 4'd13;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WRONG  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TICKS = 1'd1;

  localparam logic [3:0]  MAX_WRONG_RST  = 4'd3;
  localparam logic [23:0] LOCK_TICKS_RST = 24'd10000;
  localparam logic [3:0]  WRONG_SAT      = 4'd15;

  // Entry mode of the keypad sequencer.
  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_UNLOCK = 5'b00010,
    MODE_SET    = 5'b00100,
    MODE_OLD    = 5'b01000,
    MODE_NEW    = 5'b10000
  } kclc_mode_e;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] digit;
  } kclc_in_t;

  typedef struct packed {
    logic [3:0] status;
    logic [1:0] menu;
    logic [2:0] digits_entered;
    logic       door_open;
    logic       locked;
    logic       sound_on;
    logic       beep;
  } kclc_out_t;

endpackage

[design/keypad_code_lock_controller.sv]
// Top level of the keypad code lock controller: event decode, lock state and result register.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_stall_o  kclc_in_t  (action, digit)
//   out      output     out_valid_o/out_stall_i  kclc_out_t (status ... beep)
//   cfg      input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// Each key or tick event is handled in one pass of logic: the state update and the result
// are computed together and the result lands in the output register at the accept edge.
// A new event is accepted every cycle while the output register is empty or drains.
// A stall on the output holds the result and stalls the input in the same cycle.
// Reset returns the menu, code, entry, lockout and sound state to their initial values.
module keypad_code_lock_controller #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  kclc_pkg::kclc_in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output kclc_pkg::kclc_out_t                   out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [kclc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [kclc_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import kclc_pkg::*;

  localparam int unsigned CNT_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(CODE_DIGITS - 1);

  // Configuration registers.
  logic [3:0]  max_wrong_q;
  logic [23:0] lock_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_wrong_q  <= MAX_WRONG_RST;
      lock_ticks_q <= LOCK_TICKS_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_MAX_WRONG) begin
        max_wrong_q <= cfg_data_i[3:0];
      end
      if (cfg_index_i == CFG_LOCK_TICKS) begin
        lock_ticks_q <= cfg_data_i[23:0];
      end
    end
  end

  // Lock state.
  logic [1:0]       menu_q,   menu_d;
  logic [3:0]       stored_q [CODE_DIGITS];
  logic [3:0]       stored_d [CODE_DIGITS];
  logic             set_q,    set_d;
  logic [3:0]       buf_q    [CODE_DIGITS];
  logic [3:0]       buf_d    [CODE_DIGITS];
  logic [CNT_W-1:0] cnt_q,    cnt_d;
  kclc_mode_e       mode_q,   mode_d;
  logic [3:0]       wrong_q,  wrong_d;
  logic [23:0]      lock_q,   lock_d;
  logic             sound_q,  sound_d;

  // Output register.
  logic      out_valid_q, out_valid_d;
  kclc_out_t out_q,       out_d;

  logic        accept;
  logic [3:0]  cand [CODE_DIGITS];
  logic        match;
  logic [3:0]  wrong_inc;
  logic [23:0] lock_dec;
  logic [3:0]  status;
  logic        door;
  logic        beep;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // The full code as it stands once the incoming digit fills the last position.
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      cand[i] = (i == CODE_DIGITS - 1) ? in_data_i.digit : buf_q[i];
      if (cand[i] != stored_q[i]) begin
        match = 1'b0;
      end
    end
  end

  assign wrong_inc = (wrong_q < WRONG_SAT) ? wrong_q + 4'd1 : wrong_q;
  assign lock_dec  = lock_q - 24'd1;

  // Event decode and next state.
  always_comb begin
    menu_d   = menu_q;
    stored_d = stored_q;
    set_d    = set_q;
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    mode_d   = mode_q;
    wrong_d  = wrong_q;
    lock_d   = lock_q;
    sound_d  = sound_q;
    status   = ST_NONE;
    door     = 1'b0;
    beep     = 1'b0;

    if (in_data_i.action == ACT_TICK) begin
      if (lock_q != 24'd0) begin
        lock_d = lock_dec;
        if (lock_dec == 24'd0) begin
          wrong_d = 4'd0;
          status  = ST_RELEASED;
        end
      end
    end else if (lock_q != 24'd0) begin
      status = ST_LOCK_IGNORE;
    end else if (in_data_i.action == ACT_DOWN) begin
      if (mode_q == MODE_IDLE) begin
        menu_d = menu_q + 2'd1;
        status = ST_MENU_MOVED;
        beep   = 1'b1;
      end
    end else if (in_data_i.action == ACT_ENTER) begin
      if (mode_q == MODE_IDLE) begin
        beep = 1'b1;
        unique case (menu_q)
          MENU_ENTER: begin
            if (!set_q) begin
              status = ST_SET_FIRST;
            end else begin
              mode_d = MODE_UNLOCK;
              cnt_d  = '0;
              status = ST_ENTRY_START;
            end
          end
          MENU_SET: begin
            if (set_q) begin
              status = ST_ALREADY_SET;
            end else begin
              mode_d = MODE_SET;
              cnt_d  = '0;
              status = ST_ENTRY_START;
            end
          end
          MENU_CHANGE: begin
            if (!set_q) begin
              status = ST_SET_FIRST;
            end else begin
              mode_d = MODE_OLD;
              cnt_d  = '0;
              status = ST_ENTRY_START;
            end
          end
          default: begin
            sound_d = ~sound_q;
            status  = ST_SOUND_TOGG;
          end
        endcase
      end
    end else begin
      // Digit key: taken only while an entry is open.
      if (mode_q != MODE_IDLE && in_data_i.digit <= 4'd9) begin
        beep = 1'b1;
        if (cnt_q != LAST_POS) begin
          buf_d[cnt_q] = in_data_i.digit;
          cnt_d        = cnt_q + CNT_W'(1);
          status       = ST_DIGIT_TAKEN;
        end else begin
          cnt_d  = '0;
          mode_d = MODE_IDLE;
          unique case (mode_q) inside
            MODE_UNLOCK: begin
              if (match) begin
                status  = ST_OPENED;
                door    = 1'b1;
                wrong_d = 4'd0;
              end else begin
                wrong_d = wrong_inc;
                if (wrong_inc >= max_wrong_q) begin
                  status = ST_WRONG_LOCK;
                  lock_d = (lock_ticks_q != 24'd0) ? lock_ticks_q : 24'd1;
                end else begin
                  status = ST_WRONG;
                end
              end
            end
            MODE_SET, MODE_NEW: begin
              stored_d = cand;
              set_d    = 1'b1;
              status   = ST_STORED;
            end
            MODE_OLD: begin
              if (match) begin
                status = ST_OLD_OK;
                mode_d = MODE_NEW;
              end else begin
                status = ST_WRONG;
              end
            end
            default: begin
              mode_d = MODE_IDLE;
            end
          endcase
        end
      end
    end
  end

  // Result assembled from the post-event state.
  always_comb begin
    out_d.status         = status;
    out_d.menu           = menu_d;
    out_d.digits_entered = 3'(cnt_d);
    out_d.door_open      = door;
    out_d.locked         = (lock_d != 24'd0);
    out_d.sound_on       = sound_d;
    out_d.beep           = beep;
  end

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  // State registers update on each accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      menu_q  <= '0;
      set_q   <= 1'b0;
      cnt_q   <= '0;
      mode_q  <= MODE_IDLE;
      wrong_q <= '0;
      lock_q  <= '0;
      sound_q <= 1'b1;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        stored_q[i] <= '0;
      end
    end else if (accept) begin
      menu_q   <= menu_d;
      set_q    <= set_d;
      cnt_q    <= cnt_d;
      mode_q   <= mode_d;
      wrong_q  <= wrong_d;
      lock_q   <= lock_d;
      sound_q  <= sound_d;
      stored_q <= stored_d;
    end
  end

  // Entry buffer positions are always written before they are compared.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q <= buf_d;
    end
  end

  // Output register and its valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/kclc_checker.sv]
// Port-level assertions for the keypad code lock controller and their bind.
module kclc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input kclc_pkg::kclc_out_t out_data_o
);
  import kclc_pkg::*;

  // The door pulse comes only with an opened status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.door_open |-> out_data_o.status == ST_OPENED)
    else $error("door_open without opened status");

  // A wrong code that starts a lockout leaves the keypad locked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_WRONG_LOCK |-> out_data_o.locked)
    else $error("lockout status without locked flag");

  // A key ignored during lockout cannot end the lockout.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_LOCK_IGNORE |->
      out_data_o.locked && !out_data_o.beep && !out_data_o.door_open)
    else $error("ignored key changed lock or gave feedback");

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind keypad_code_lock_controller kclc_checker u_kclc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[tb/tb_top.sv]
// Self-checking testbench for the keypad code lock controller.
module tb_top;
  import kclc_pkg::*;

  localparam int DIGITS = 4;
  localparam int unsigned TIMEOUT_CYCLES = 600000;

  typedef logic [0:DIGITS-1][3:0] code_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  kclc_in_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  kclc_out_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Lock state as the testbench expects it to evolve.
  logic [1:0]  menu_sel;
  code_t       code_store;
  bit          code_valid;
  code_t       entry_buf;
  logic [2:0]  entry_cnt;
  kclc_mode_e  entry_state;
  logic [3:0]  wrong_tries;
  logic [23:0] lock_left;
  bit          sound_en;
  logic [3:0]  cfg_max_wrong;
  logic [23:0] cfg_lock_ticks;

  kclc_out_t   expected_q [$];
  int unsigned tx_gap_max   = 0;
  int unsigned rx_stall_max = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;
  int unsigned wait_left    = 0;
  int unsigned events_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned status_seen [16];
  int unsigned errors       = 0;

  keypad_code_lock_controller DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock with a period of 12 time units.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Advance the expected lock state by one key or tick event and form its result.
  task automatic apply_event(input kclc_in_t ev, output kclc_out_t res);
    logic [3:0] st;
    logic       door;
    logic       tone;
    bit         match;
    st   = ST_NONE;
    door = 1'b0;
    tone = 1'b0;
    if (ev.action == ACT_TICK) begin
      if (lock_left != 0) begin
        lock_left = lock_left - 24'd1;
        if (lock_left == 0) begin
          wrong_tries = '0;
          st = ST_RELEASED;
        end
      end
    end else if (lock_left != 0) begin
      st = ST_LOCK_IGNORE;
    end else if (ev.action == ACT_DOWN) begin
      if (entry_state == MODE_IDLE) begin
        menu_sel = menu_sel + 2'd1;
        st = ST_MENU_MOVED;
        tone = 1'b1;
      end
    end else if (ev.action == ACT_ENTER) begin
      if (entry_state == MODE_IDLE) begin
        tone = 1'b1;
        st = ST_ENTRY_START;
        case (menu_sel)
          MENU_ENTER: begin
            if (!code_valid) st = ST_SET_FIRST;
            else entry_state = MODE_UNLOCK;
          end
          MENU_SET: begin
            if (code_valid) st = ST_ALREADY_SET;
            else entry_state = MODE_SET;
          end
          MENU_CHANGE: begin
            if (!code_valid) st = ST_SET_FIRST;
            else entry_state = MODE_OLD;
          end
          default: begin
            sound_en = !sound_en;
            st = ST_SOUND_TOGG;
          end
        endcase
        if (st == ST_ENTRY_START) begin
          entry_buf = '0;
          entry_cnt = '0;
        end
      end
    end else if (entry_state != MODE_IDLE && ev.digit <= 4'd9 && entry_cnt < DIGITS) begin
      entry_buf[entry_cnt[1:0]] = ev.digit;
      entry_cnt = entry_cnt + 3'd1;
      tone = 1'b1;
      st = ST_DIGIT_TAKEN;
      // The last digit closes the entry: check it or store it.
      if (entry_cnt == DIGITS) begin
        match = (entry_buf == code_store);
        case (entry_state)
          MODE_UNLOCK: begin
            if (match) begin
              st = ST_OPENED;
              door = 1'b1;
              wrong_tries = '0;
            end else begin
              if (wrong_tries < WRONG_SAT) wrong_tries = wrong_tries + 4'd1;
              if (wrong_tries >= cfg_max_wrong) begin
                st = ST_WRONG_LOCK;
                lock_left = (cfg_lock_ticks != 0) ? cfg_lock_ticks : 24'd1;
              end else begin
                st = ST_WRONG;
              end
            end
            entry_state = MODE_IDLE;
          end
          MODE_SET, MODE_NEW: begin
            code_store = entry_buf;
            code_valid = 1'b1;
            st = ST_STORED;
            entry_state = MODE_IDLE;
          end
          MODE_OLD: begin
            if (match) begin
              st = ST_OLD_OK;
              entry_state = MODE_NEW;
            end else begin
              st = ST_WRONG;
              entry_state = MODE_IDLE;
            end
          end
          default: entry_state = MODE_IDLE;
        endcase
        entry_buf = '0;
        entry_cnt = '0;
      end
    end
    res.status         = st;
    res.menu           = menu_sel;
    res.digits_entered = entry_cnt;
    res.door_open      = door;
    res.locked         = (lock_left != 0);
    res.sound_on       = sound_en;
    res.beep           = tone;
  endtask

  // Offer one event after a random gap and record its expected result on acceptance.
  task automatic send_event(input logic [1:0] act, input logic [3:0] dig);
    int unsigned gap;
    kclc_in_t    ev;
    kclc_out_t   res;
    gap = $urandom_range(0, tx_gap_max);
    ev.action = act;
    ev.digit  = dig;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    apply_event(ev, res);
    expected_q.push_back(res);
    events_sent++;
  endtask

  // Stop offering events and wait until every expected result has arrived.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write one configuration register; the block must be idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAX_WRONG) cfg_max_wrong = val[3:0];
    else cfg_lock_ticks = val;
    @(posedge clk_i);
  endtask

  function automatic code_t random_code();
    code_t c;
    for (int i = 0; i < DIGITS; i++) c[i] = 4'($urandom_range(0, 9));
    return c;
  endfunction

  // Key in a full code, first digit first.
  task automatic key_code(input code_t c);
    for (int i = 0; i < DIGITS; i++) begin
      // Now and then a tick, a stray key or an out-of-range digit lands mid-entry.
      if ($urandom_range(0, 11) == 0)
        send_event(2'($urandom_range(0, 3)), 4'($urandom_range(10, 15)));
      send_event(ACT_DIGIT, c[i]);
    end
  endtask

  // Scroll the menu to an option; the keypad must be idle and not locked.
  task automatic goto_menu(input logic [1:0] target);
    while (menu_sel != target) send_event(ACT_DOWN, 4'($urandom_range(0, 15)));
  endtask

  task automatic attempt_unlock(input bit right);
    code_t guess;
    guess = code_store;
    if (!right) guess[0] = (guess[0] == 4'd9) ? 4'd0 : guess[0] + 4'd1;
    goto_menu(MENU_ENTER);
    send_event(ACT_ENTER, 4'($urandom_range(0, 15)));
    if (entry_state == MODE_UNLOCK) key_code(guess);
  endtask

  // Close an open entry and wait out any lockout, with a few ignored keys on the way.
  task automatic reach_idle();
    while (entry_state != MODE_IDLE) send_event(ACT_DIGIT, 4'($urandom_range(0, 9)));
    while (lock_left != 0) begin
      if ($urandom_range(0, 4) == 0)
        send_event(2'($urandom_range(0, 2)), 4'($urandom_range(0, 15)));
      else send_event(ACT_TICK, 4'($urandom_range(0, 15)));
    end
  endtask

  // One user session: mostly complete menu operations, some random key noise.
  task automatic random_session();
    int unsigned pick;
    reach_idle();
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      attempt_unlock($urandom_range(0, 9) < 6);
    end else if (pick < 60) begin
      goto_menu(MENU_CHANGE);
      send_event(ACT_ENTER, 4'($urandom_range(0, 15)));
      if (entry_state == MODE_OLD)
        key_code(($urandom_range(0, 9) < 7) ? code_store : random_code());
      if (entry_state == MODE_NEW) key_code(random_code());
    end else if (pick < 65) begin
      goto_menu(MENU_SET);
      send_event(ACT_ENTER, 4'($urandom_range(0, 15)));
      if (entry_state == MODE_SET) key_code(random_code());
    end else if (pick < 75) begin
      goto_menu(MENU_SOUND);
      send_event(ACT_ENTER, 4'($urandom_range(0, 15)));
    end else begin
      repeat ($urandom_range(1, 6))
        send_event(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    end
  endtask

  // Menu scrolling, refusals before a code exists, sound toggle and the first code store.
  task automatic test_menu_and_set();
    tx_gap_max   = 4;
    rx_stall_max = 4;
    send_event(ACT_TICK, 4'd0);     // tick with no lockout
    send_event(ACT_DIGIT, 4'd7);    // digit with no entry open
    send_event(ACT_ENTER, 4'd0);    // enter code before a code is set
    send_event(ACT_DOWN, 4'd0);
    send_event(ACT_DOWN, 4'd0);
    send_event(ACT_ENTER, 4'd0);    // change with no code set
    send_event(ACT_DOWN, 4'd0);
    send_event(ACT_ENTER, 4'd0);    // sound off
    send_event(ACT_DOWN, 4'd0);     // menu wraps to the first option
    send_event(ACT_DOWN, 4'd15);
    send_event(ACT_ENTER, 4'd0);    // open the set-code entry
    send_event(ACT_DIGIT, 4'd9);
    send_event(ACT_DIGIT, 4'd15);   // digits above nine are ignored
    send_event(ACT_DIGIT, 4'd10);
    send_event(ACT_DOWN, 4'd0);     // down and enter are ignored during an entry
    send_event(ACT_ENTER, 4'd0);
    send_event(ACT_TICK, 4'd0);
    send_event(ACT_DIGIT, 4'd0);
    send_event(ACT_DIGIT, 4'd8);
    send_event(ACT_DIGIT, 4'd3);    // last digit stores the code
    send_event(ACT_ENTER, 4'd0);    // set refused once a code exists
  endtask

  // Code change with a wrong and a right old code, then unlock tries.
  task automatic test_code_checks();
    goto_menu(MENU_CHANGE);
    send_event(ACT_ENTER, 4'd0);
    key_code({4'd9, 4'd0, 4'd8, 4'd4});
    send_event(ACT_ENTER, 4'd0);
    key_code(code_store);
    key_code({4'd0, 4'd0, 4'd0, 4'd0});
    goto_menu(MENU_SOUND);
    send_event(ACT_ENTER, 4'd0);
    goto_menu(MENU_ENTER);
    send_event(ACT_ENTER, 4'd0);
    key_code({4'd9, 4'd9, 4'd9, 4'd9});
    send_event(ACT_ENTER, 4'd0);
    key_code({4'd0, 4'd0, 4'd0, 4'd0});
  endtask

  // Lockout at the register extremes: zero tries and zero ticks, then fifteen tries.
  task automatic test_lockout_limits();
    settle();
    write_reg(CFG_MAX_WRONG, '0);
    write_reg(CFG_LOCK_TICKS, '0);
    attempt_unlock(1'b0);
    send_event(ACT_DIGIT, 4'd1);
    send_event(ACT_DOWN, 4'd0);
    send_event(ACT_ENTER, 4'd0);
    send_event(ACT_TICK, 4'd0);
    send_event(ACT_TICK, 4'd0);
    settle();
    write_reg(CFG_MAX_WRONG, 24'd15);
    write_reg(CFG_LOCK_TICKS, 24'd3);
    repeat (15) attempt_unlock(1'b0);
    reach_idle();
    attempt_unlock(1'b1);
  endtask

  // The receiver holds off for a long stretch while events keep coming.
  task automatic test_backpressure();
    settle();
    tx_gap_max   = 0;
    rx_stall_max = 0;
    hold_request = 150;
    repeat (16) send_event(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    settle();
  endtask

  task automatic test_random_phase(input logic [3:0] tries, input logic [23:0] ticks,
                                   input int unsigned n_items, input int unsigned gap_max,
                                   input int unsigned stall_max);
    int unsigned stop_at;
    settle();
    write_reg(CFG_MAX_WRONG, CFG_DATA_W'(tries));
    write_reg(CFG_LOCK_TICKS, ticks);
    tx_gap_max   = gap_max;
    rx_stall_max = stall_max;
    stop_at = events_sent + n_items;
    while (events_sent < stop_at) random_session();
  endtask

  // The longest lockout: once in force it outlasts the run.
  task automatic test_endless_lockout();
    reach_idle();
    settle();
    write_reg(CFG_MAX_WRONG, 24'd1);
    write_reg(CFG_LOCK_TICKS, 24'hFFFFFF);
    tx_gap_max   = 2;
    rx_stall_max = 2;
    attempt_unlock(1'b0);
    repeat (40) send_event(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
  endtask

  // Stimulus sequence.
  initial begin
    menu_sel       = MENU_ENTER;
    code_store     = '0;
    code_valid     = 1'b0;
    entry_buf      = '0;
    entry_cnt      = '0;
    entry_state    = MODE_IDLE;
    wrong_tries    = '0;
    lock_left      = '0;
    sound_en       = 1'b1;
    cfg_max_wrong  = MAX_WRONG_RST;
    cfg_lock_ticks = LOCK_TICKS_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_menu_and_set();
    test_code_checks();
    test_lockout_limits();
    test_random_phase(4'd3, 24'd4, 250, 0, 0);
    test_backpressure();
    test_random_phase(4'd1, 24'd1, 250, 16, 3);
    test_random_phase(4'd2, 24'd9, 250, 3, 16);
    test_random_phase(4'd15, 24'd2, 200, 16, 16);
    test_random_phase(4'($urandom_range(1, 15)), 24'($urandom_range(1, 20)), 250, 4, 4);
    test_endless_lockout();

    settle();
    repeat (4) @(posedge clk_i);
    $display("Covered %0d key and tick events with %0d results checked over several settings.",
             events_sent, results_seen);
    $display("Doors opened %0d times, lockouts %0d, releases %0d, locked keys ignored %0d.",
             status_seen[ST_OPENED], status_seen[ST_WRONG_LOCK], status_seen[ST_RELEASED],
             status_seen[ST_LOCK_IGNORE]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Output stall: a random wait per result, plus the long hold-off on request.
  always @(posedge clk_i) begin : stall_ctrl
    logic stall_next;
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      wait_left = $urandom_range(0, rx_stall_max);
      stall_next = (wait_left != 0);
      if (wait_left != 0) wait_left--;
    end else if (wait_left != 0) begin
      wait_left--;
      stall_next = 1'b1;
    end else begin
      stall_next = 1'b0;
    end
    out_stall_i <= stall_next;
  end

  task automatic compare_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Compare every accepted result transaction with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    kclc_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_seen++;
      status_seen[out_data_o.status]++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_data_o);
        errors++;
      end else begin
        want = expected_q.pop_front();
        compare_field("status", 8'(want.status), 8'(out_data_o.status));
        compare_field("menu", 8'(want.menu), 8'(out_data_o.menu));
        compare_field("digits_entered", 8'(want.digits_entered),
                      8'(out_data_o.digits_entered));
        compare_field("door_open", 8'(want.door_open), 8'(out_data_o.door_open));
        compare_field("locked", 8'(want.locked), 8'(out_data_o.locked));
        compare_field("sound_on", 8'(want.sound_on), 8'(out_data_o.sound_on));
        compare_field("beep", 8'(want.beep), 8'(out_data_o.beep));
      end
    end
  end

  // Run limit.
  initial begin
    #(TIMEOUT_CYCLES * 12);
    $display("TEST FAILED");
    $finish;
  end

endmodule
